FILE: design/dde_pkg.sv
// ----------------------------------------------------------------------------
// dde_pkg: shared types and constants for the odometry goal-steer unit
// fixed-point constants, register map, controller states and datapath commands
// ----------------------------------------------------------------------------
package dde_pkg;

  // cordic configuration
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 24;

  // divider length, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 48;

  // shared multiplier operand and product widths
  localparam int unsigned MA_W = 37;
  localparam int unsigned MB_W = 25;
  localparam int unsigned MP_W = MA_W + MB_W;

  // q16.16 angle constants at 22 bits, two pi also at 20 bits, and the inverse cordic gain
  localparam logic signed [21:0] PI22      = 22'sd205887;
  localparam logic signed [21:0] HALF_PI22 = 22'sd102944;
  localparam logic signed [21:0] TWO_PI22  = 22'sd411775;
  localparam logic [19:0]        TWO_PI_U  = 20'd411775;
  localparam logic signed [37:0] INV_K38   = 38'sd39797;
  localparam logic signed [24:0] INV_K25   = 25'sd39797;

  // drive limits in q16.16
  localparam logic [23:0]        LIN_MAX = 24'd9830400;
  localparam logic signed [45:0] ANG_MAX = 46'sd6553600;

  // register reset values
  localparam logic [15:0] RADIUS_RST = 16'd1966;
  localparam logic [19:0] BASE_RST   = 20'd9830;
  localparam logic [23:0] LGAIN_RST  = 24'd6553600;
  localparam logic [23:0] AGAIN_RST  = 24'd3276800;
  localparam logic [15:0] TOL_RST    = 16'd1638;

  // register indexes
  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_BASE   = 3'd1,
    REG_LGAIN  = 3'd2,
    REG_AGAIN  = 3'd3,
    REG_GOAL_X = 3'd4,
    REG_GOAL_Y = 3'd5,
    REG_TOL    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        wheel_radius;
    logic [19:0]        wheel_base;
    logic [23:0]        linear_gain;
    logic [23:0]        angular_gain;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [15:0]        arrive_tolerance;
  } cfg_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_MDIFF, S_DINIT, S_MSUM, S_TRAV, S_DIV, S_COURSE, S_RINIT, S_ROT,
    S_RDONE, S_MCOS, S_ADDX, S_MSIN, S_ADDY, S_VINIT, S_VEC, S_MMAG, S_DIST,
    S_MLIN, S_MANG, S_DRIVE, S_OUT
  } state_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MDIFF, OP_DINIT, OP_MSUM, OP_TRAV, OP_DSTEP, OP_COURSE,
    OP_RINIT, OP_CSTEP, OP_RDONE, OP_MCOS, OP_ADDX, OP_MSIN, OP_ADDY, OP_VINIT,
    OP_MMAG, OP_DIST, OP_MLIN, OP_MANG, OP_DRIVE, OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] iter;
  } cmd_t;

  // arctangent of 2^-i in q16.16, rounded to nearest
  function automatic logic [15:0] atan_entry(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'd51472;
      5'd1:    r = 16'd30386;
      5'd2:    r = 16'd16055;
      5'd3:    r = 16'd8150;
      5'd4:    r = 16'd4091;
      5'd5:    r = 16'd2047;
      5'd6:    r = 16'd1024;
      5'd7:    r = 16'd512;
      5'd8:    r = 16'd256;
      5'd9:    r = 16'd128;
      5'd10:   r = 16'd64;
      5'd11:   r = 16'd32;
      5'd12:   r = 16'd16;
      5'd13:   r = 16'd8;
      5'd14:   r = 16'd4;
      5'd15:   r = 16'd2;
      5'd16:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // single wrap by 2pi into [-pi, pi]
  function automatic logic signed [21:0] wrap_pi(input logic signed [21:0] a);
    logic signed [21:0] r;
    r = a;
    if (a > PI22) begin
      r = a - TWO_PI22;
    end else if (a < -PI22) begin
      r = a + TWO_PI22;
    end
    return r;
  endfunction

  // saturate to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 47'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -47'sd2147483648) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

FILE: design/dde_regs.sv
// ----------------------------------------------------------------------------
// dde_regs: configuration register file
// apb-style write and read access to the seven steering registers
// ----------------------------------------------------------------------------
module dde_regs import dde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_radius     <= RADIUS_RST;
      cfg_q.wheel_base       <= BASE_RST;
      cfg_q.linear_gain      <= LGAIN_RST;
      cfg_q.angular_gain     <= AGAIN_RST;
      cfg_q.goal_x           <= '0;
      cfg_q.goal_y           <= '0;
      cfg_q.arrive_tolerance <= TOL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_RADIUS: cfg_q.wheel_radius     <= pwdata[15:0];
        REG_BASE:   cfg_q.wheel_base       <= pwdata[19:0];
        REG_LGAIN:  cfg_q.linear_gain      <= pwdata[23:0];
        REG_AGAIN:  cfg_q.angular_gain     <= pwdata[23:0];
        REG_GOAL_X: cfg_q.goal_x           <= pwdata;
        REG_GOAL_Y: cfg_q.goal_y           <= pwdata;
        REG_TOL:    cfg_q.arrive_tolerance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_RADIUS: prdata = {16'd0, cfg_q.wheel_radius};
      REG_BASE:   prdata = {12'd0, cfg_q.wheel_base};
      REG_LGAIN:  prdata = {8'd0, cfg_q.linear_gain};
      REG_AGAIN:  prdata = {8'd0, cfg_q.angular_gain};
      REG_GOAL_X: prdata = cfg_q.goal_x;
      REG_GOAL_Y: prdata = cfg_q.goal_y;
      REG_TOL:    prdata = {16'd0, cfg_q.arrive_tolerance};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/dde_ctrl.sv
// ----------------------------------------------------------------------------
// dde_ctrl: sequencing state machine
// steps the datapath through odometry, cordic, division and drive laws
// ----------------------------------------------------------------------------
module dde_ctrl import dde_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  localparam int unsigned NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free, load_out;
  logic       div_last, cor_last;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign load_out    = (state_q == S_OUT) & out_free;
  assign div_last    = (cnt_q == 6'(DIV_STEPS - 1));
  assign cor_last    = (cnt_q == 6'(NSTEPS - 1));
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_MDIFF;
      S_MDIFF:  state_d = S_DINIT;
      S_DINIT:  state_d = S_MSUM;
      S_MSUM:   state_d = S_TRAV;
      S_TRAV:   state_d = S_DIV;
      S_DIV:    if (div_last) state_d = S_COURSE;
      S_COURSE: state_d = S_RINIT;
      S_RINIT:  state_d = S_ROT;
      S_ROT:    if (cor_last) state_d = S_RDONE;
      S_RDONE:  state_d = S_MCOS;
      S_MCOS:   state_d = S_ADDX;
      S_ADDX:   state_d = S_MSIN;
      S_MSIN:   state_d = S_ADDY;
      S_ADDY:   state_d = S_VINIT;
      S_VINIT:  state_d = S_VEC;
      S_VEC:    if (cor_last) state_d = S_MMAG;
      S_MMAG:   state_d = S_DIST;
      S_DIST:   state_d = S_MLIN;
      S_MLIN:   state_d = S_MANG;
      S_MANG:   state_d = S_DRIVE;
      S_DRIVE:  state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // iteration counter and output word valid
  always_comb begin
    cnt_d = '0;
    if ((state_q == S_DIV) || (state_q == S_ROT) || (state_q == S_VEC)) begin
      cnt_d = cnt_q + 6'd1;
    end
    out_valid_d = out_valid_q & out_stall_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o.iter = cnt_q;
    case (state_q)
      S_IDLE:   cmd_o.op = accept ? OP_LOAD : OP_NONE;
      S_MDIFF:  cmd_o.op = OP_MDIFF;
      S_DINIT:  cmd_o.op = OP_DINIT;
      S_MSUM:   cmd_o.op = OP_MSUM;
      S_TRAV:   cmd_o.op = OP_TRAV;
      S_DIV:    cmd_o.op = OP_DSTEP;
      S_COURSE: cmd_o.op = OP_COURSE;
      S_RINIT:  cmd_o.op = OP_RINIT;
      S_ROT:    cmd_o.op = OP_CSTEP;
      S_RDONE:  cmd_o.op = OP_RDONE;
      S_MCOS:   cmd_o.op = OP_MCOS;
      S_ADDX:   cmd_o.op = OP_ADDX;
      S_MSIN:   cmd_o.op = OP_MSIN;
      S_ADDY:   cmd_o.op = OP_ADDY;
      S_VINIT:  cmd_o.op = OP_VINIT;
      S_VEC:    cmd_o.op = OP_CSTEP;
      S_MMAG:   cmd_o.op = OP_MMAG;
      S_DIST:   cmd_o.op = OP_DIST;
      S_MLIN:   cmd_o.op = OP_MLIN;
      S_MANG:   cmd_o.op = OP_MANG;
      S_DRIVE:  cmd_o.op = OP_DRIVE;
      S_OUT:    cmd_o.op = out_free ? OP_OUT : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MDIFF)) else $error("accepted word did not start work");

  a_div_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < 6'(DIV_STEPS))) else $error("divider overran");

  a_cordic_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ROT) || (state_q == S_VEC)) |-> (cnt_q < 6'(NSTEPS)))
    else $error("cordic overran");

  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("stray output word");

endmodule

FILE: design/dde_dp.sv
// ----------------------------------------------------------------------------
// dde_dp: odometry and steering datapath
// shared multiplier, bit-serial divider with modulo, shared cordic, drive laws
// ----------------------------------------------------------------------------
module dde_dp import dde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] left_angle_i,
  input  logic signed [31:0] right_angle_i,
  output logic signed [8:0]  pwm_left_o,
  output logic signed [8:0]  pwm_right_o,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic [30:0]        goal_distance_o,
  output logic signed [18:0] heading_error_o,
  output logic               arrived_o
);

  // state
  logic signed [31:0] last_l_q, last_r_q, pos_x_q, pos_y_q;
  // working registers
  logic signed [32:0] diff_q;
  logic signed [33:0] sum_q;
  logic signed [MP_W-1:0] prod_q;
  logic [47:0]        num_q;
  logic [19:0]        rem_q;
  logic               qneg_q;
  logic [18:0]        modm_q;
  logic signed [18:0] course_q;
  logic signed [32:0] travel_q;
  logic signed [37:0] x_q, y_q;
  logic signed [20:0] z_q;
  logic               rot_q, flip_q, vzero_q;
  logic signed [18:0] c_q, s_q;
  logic [30:0]        dist_q;
  logic signed [18:0] heading_q;
  logic [23:0]        lin_q;
  logic signed [8:0]  pl_q, pr_q;
  logic               arr_q;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MDIFF: begin
        mul_a = MA_W'(diff_q);
        mul_b = $signed({9'd0, cfg_i.wheel_radius});
      end
      OP_MSUM: begin
        mul_a = MA_W'(sum_q);
        mul_b = $signed({9'd0, cfg_i.wheel_radius});
      end
      OP_MCOS: begin
        mul_a = MA_W'(travel_q);
        mul_b = MB_W'(c_q);
      end
      OP_MSIN: begin
        mul_a = MA_W'(travel_q);
        mul_b = MB_W'(s_q);
      end
      OP_MMAG: begin
        mul_a = vzero_q ? '0 : x_q[MA_W-1:0];
        mul_b = INV_K25;
      end
      OP_MLIN: begin
        mul_a = $signed({6'd0, dist_q});
        mul_b = $signed({1'b0, cfg_i.linear_gain});
      end
      OP_MANG: begin
        mul_a = MA_W'(heading_q);
        mul_b = $signed({1'b0, cfg_i.angular_gain});
      end
      default: ;
    endcase
  end

  // divider and modulo step
  logic [19:0] divisor;
  logic [20:0] trial;
  logic        ge;
  logic [19:0] rem_nx, m2;
  logic [18:0] mod_nx;
  logic signed [MP_W-1:0] prod_abs;

  assign divisor  = (cfg_i.wheel_base == '0) ? 20'd1 : cfg_i.wheel_base;
  assign trial    = {rem_q, num_q[47]};
  assign ge       = (trial >= {1'b0, divisor});
  assign rem_nx   = ge ? 20'(trial - {1'b0, divisor}) : trial[19:0];
  assign m2       = {modm_q, ge};
  assign mod_nx   = (m2 >= TWO_PI_U) ? 19'(m2 - TWO_PI_U) : m2[18:0];
  assign prod_abs = prod_q[MP_W-1] ? -prod_q : prod_q;

  // course from signed remainder
  logic signed [21:0] course_raw, course_w, course_x;
  assign course_raw = qneg_q ? -$signed({3'b000, modm_q}) : $signed({3'b000, modm_q});
  assign course_w   = wrap_pi(course_raw);
  assign course_x   = 22'(course_q);

  // cordic micro-rotation
  logic [4:0]         sh;
  logic signed [37:0] xs, ys;
  logic signed [20:0] atan_s;
  logic               cneg;
  assign sh     = cmd_i.iter[4:0];
  assign xs     = x_q >>> sh;
  assign ys     = y_q >>> sh;
  assign atan_s = $signed({5'd0, atan_entry(sh)});
  assign cneg   = rot_q ? z_q[20] : (y_q > 38'sd0);

  // pose accumulation
  logic signed [46:0] acc_x, acc_y;
  assign acc_x = $signed({prod_q[MP_W-1], prod_q[MP_W-1:16]})
               + $signed({{15{pos_x_q[31]}}, pos_x_q});
  assign acc_y = $signed({prod_q[MP_W-1], prod_q[MP_W-1:16]})
               + $signed({{15{pos_y_q[31]}}, pos_y_q});

  // goal vector
  logic signed [32:0] gx, gy;
  assign gx = $signed({cfg_i.goal_x[31], cfg_i.goal_x}) - $signed({pos_x_q[31], pos_x_q});
  assign gy = $signed({cfg_i.goal_y[31], cfg_i.goal_y}) - $signed({pos_y_q[31], pos_y_q});

  // bearing and heading
  logic signed [21:0] bearing, heading_w;
  assign bearing   = vzero_q ? '0 : wrap_pi(22'(z_q));
  assign heading_w = wrap_pi(bearing - course_x);

  // drive laws
  logic signed [45:0] ang_full;
  logic signed [24:0] ang_c;
  logic signed [25:0] spr, spl, tr, tl;
  logic               arrived_w;
  always_comb begin
    ang_full = $signed(prod_q[MP_W-1:16]);
    if (ang_full > ANG_MAX) begin
      ang_c = 25'sd6553600;
    end else if (ang_full < -ANG_MAX) begin
      ang_c = -25'sd6553600;
    end else begin
      ang_c = ang_full[24:0];
    end
    spr = $signed({2'b00, lin_q}) + 26'(ang_c);
    spl = $signed({2'b00, lin_q}) - 26'(ang_c);
    tr  = spr[25] ? spr + 26'sd65535 : spr;
    tl  = spl[25] ? spl + 26'sd65535 : spl;
    arrived_w = (dist_q <= {15'd0, cfg_i.arrive_tolerance});
  end

  // pose and previous angles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          last_l_q <= left_angle_i;
          last_r_q <= right_angle_i;
        end
        OP_ADDX: pos_x_q <= sat32(acc_x);
        OP_ADDY: pos_y_q <= sat32(acc_y);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MDIFF, OP_MSUM, OP_MCOS, OP_MSIN, OP_MMAG, OP_MLIN, OP_MANG:
        prod_q <= mul_a * mul_b;
      default: ;
    endcase
    case (cmd_i.op)
      OP_LOAD: begin
        diff_q <= $signed({right_angle_i[31], right_angle_i})
                - $signed({left_angle_i[31], left_angle_i});
        sum_q  <= $signed({{2{left_angle_i[31]}}, left_angle_i})
                + $signed({{2{right_angle_i[31]}}, right_angle_i})
                - $signed({{2{last_l_q[31]}}, last_l_q})
                - $signed({{2{last_r_q[31]}}, last_r_q});
      end
      OP_DINIT: begin
        num_q  <= prod_abs[47:0];
        qneg_q <= prod_q[MP_W-1];
        rem_q  <= '0;
        modm_q <= '0;
      end
      OP_TRAV: travel_q <= prod_q[49:17];
      OP_DSTEP: begin
        rem_q  <= rem_nx;
        num_q  <= {num_q[46:0], 1'b0};
        modm_q <= mod_nx;
      end
      OP_COURSE: course_q <= course_w[18:0];
      OP_RINIT: begin
        x_q   <= INV_K38;
        y_q   <= '0;
        rot_q <= 1'b1;
        if (course_x > HALF_PI22) begin
          z_q    <= 21'(course_x - PI22);
          flip_q <= 1'b1;
        end else if (course_x < -HALF_PI22) begin
          z_q    <= 21'(course_x + PI22);
          flip_q <= 1'b1;
        end else begin
          z_q    <= 21'(course_x);
          flip_q <= 1'b0;
        end
      end
      OP_CSTEP: begin
        if (cneg) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_s;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_s;
        end
      end
      OP_RDONE: begin
        c_q <= flip_q ? -x_q[18:0] : x_q[18:0];
        s_q <= flip_q ? -y_q[18:0] : y_q[18:0];
      end
      OP_VINIT: begin
        rot_q   <= 1'b0;
        vzero_q <= (gx == '0) && (gy == '0);
        if (gx[32]) begin
          x_q <= -38'(gx);
          y_q <= -38'(gy);
          z_q <= gy[32] ? 21'(-PI22) : 21'(PI22);
        end else begin
          x_q <= 38'(gx);
          y_q <= 38'(gy);
          z_q <= '0;
        end
      end
      OP_DIST: begin
        if (prod_q[MP_W-1]) begin
          dist_q <= '0;
        end else if (|prod_q[MP_W-2:47]) begin
          dist_q <= '1;
        end else begin
          dist_q <= prod_q[46:16];
        end
        heading_q <= heading_w[18:0];
      end
      OP_MANG: begin
        if ((|prod_q[MP_W-1:40]) || (prod_q[39:16] > LIN_MAX)) begin
          lin_q <= LIN_MAX;
        end else begin
          lin_q <= prod_q[39:16];
        end
      end
      OP_DRIVE: begin
        arr_q <= arrived_w;
        pr_q  <= arrived_w ? '0 : tr[24:16];
        pl_q  <= arrived_w ? '0 : tl[24:16];
      end
      OP_OUT: begin
        pwm_left_o      <= pl_q;
        pwm_right_o     <= pr_q;
        pose_x_o        <= pos_x_q;
        pose_y_o        <= pos_y_q;
        goal_distance_o <= dist_q;
        heading_error_o <= heading_q;
        arrived_o       <= arr_q;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/diff_drive_odometry_goal_steer_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_goal_steer_unit: odometry with go-to-goal steering
// wheel angles in, pose estimate, goal distance, heading error and pwm out
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid_i/in_stall_o | left_angle_i, right_angle_i
//  out      | output    | out_valid_o/out_stall_i | pwm, pose, distance, heading
//  cfg      | apb       | psel/penable/pwrite   | paddr, pwdata, prdata
//
//  from acceptance to result a word passes the odometry multiplies, the 48-step
//  course divider, the two cordic passes and the drive laws
//  a new word is accepted in the idle cycle after the result is registered
//  a stalled result holds in the output register; work stops only at that point
//  reset restores register defaults and clears pose and previous angles
// ----------------------------------------------------------------------------
module diff_drive_odometry_goal_steer_unit import dde_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] left_angle_i,
  input  logic signed [31:0] right_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [8:0]  pwm_left_o,
  output logic signed [8:0]  pwm_right_o,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic [30:0]        goal_distance_o,
  output logic signed [18:0] heading_error_o,
  output logic               arrived_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  dde_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  dde_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath
  dde_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .left_angle_i    (left_angle_i),
    .right_angle_i   (right_angle_i),
    .pwm_left_o      (pwm_left_o),
    .pwm_right_o     (pwm_right_o),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .goal_distance_o (goal_distance_o),
    .heading_error_o (heading_error_o),
    .arrived_o       (arrived_o)
  );

endmodule
